>>> design/bnms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and constants for the box suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

    localparam int FIELD_W = 16;
    localparam int SCORE_W = 16;
    localparam int IDX_W   = 6;
    localparam int THR_W   = 16;
    localparam int MODE_W  = 2;
    localparam int PIX     = 16;

    localparam logic [MODE_W-1:0] MODE_IOU  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_MODE      = 1'b1;

    localparam logic [THR_W-1:0]  THR_RESET  = 16'd26214;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_IOU;

    typedef enum logic [2:0] {
        OP_HOLD   = 3'b001,
        OP_INSERT = 3'b010,
        OP_SHIFT  = 3'b100
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [SCORE_W-1:0] new_score;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_ROT  = 3'b100
    } state_t;

endpackage
`default_nettype wire

>>> design/bnms_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnms_box_if / bnms_kept_if
// Valid/ready channels for incoming boxes and kept boxes.
// ----------------------------------------------------------------------------
interface bnms_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_x_min;
    logic signed [15:0] box_y_min;
    logic signed [15:0] box_x_max;
    logic signed [15:0] box_y_max;
    logic        [15:0] box_score;
    logic               last_box;

    modport source (output valid, box_x_min, box_y_min, box_x_max, box_y_max,
                    box_score, last_box, input ready);
    modport sink (input valid, box_x_min, box_y_min, box_x_max, box_y_max,
                  box_score, last_box, output ready);
endinterface

interface bnms_kept_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] kept_x_min;
    logic signed [15:0] kept_y_min;
    logic signed [15:0] kept_x_max;
    logic signed [15:0] kept_y_max;
    logic        [15:0] kept_score;
    logic        [5:0]  kept_index;
    logic               dropped_some;
    logic               final_kept;

    modport source (output valid, kept_x_min, kept_y_min, kept_x_max, kept_y_max,
                    kept_score, kept_index, dropped_some, final_kept, input ready);
    modport sink (input valid, kept_x_min, kept_y_min, kept_x_max, kept_y_max,
                  kept_score, kept_index, dropped_some, final_kept, output ready);
endinterface
`default_nettype wire

>>> design/bnms_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnms_cell
// One slot of the ranked box chain: sorted insert or shift toward the head.
// ----------------------------------------------------------------------------
module bnms_cell #(
    parameter int COORD_BITS = 16,
    localparam int REC_W = 4 * COORD_BITS + bnms_pkg::SCORE_W + bnms_pkg::IDX_W + 2
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  bnms_pkg::cell_ctl_t   ctl,
    input  wire  [REC_W-1:0]      new_rec,
    input  wire  [REC_W-1:0]      left_rec,
    input  wire  [REC_W-1:0]      right_rec,
    input  wire                   below_left,
    output logic [REC_W-1:0]      rec,
    output logic                  below
);
    localparam int SC_LSB  = 4 * COORD_BITS;
    localparam int VAL_BIT = REC_W - 1;

    logic [REC_W-1:0] rec_reg;
    logic [REC_W-1:0] rec_next;

    // new box ranks behind any equal score already held
    assign below = !rec_reg[VAL_BIT] ||
                   (ctl.new_score > rec_reg[SC_LSB +: bnms_pkg::SCORE_W]);
    assign rec   = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        case (ctl.op)
            bnms_pkg::OP_INSERT:
            begin
                if (below && !below_left)
                begin
                    rec_next = new_rec;
                end
                else if (below)
                begin
                    rec_next = left_rec;
                end
            end
            bnms_pkg::OP_SHIFT:
            begin
                rec_next = right_rec;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

endmodule
`default_nettype wire

>>> design/bnms_overlap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnms_overlap
// Four-stage overlap test of each passing box against the selected box.
// ----------------------------------------------------------------------------
module bnms_overlap #(
    parameter int COORD_BITS = 16,
    localparam int REC_W = 4 * COORD_BITS + bnms_pkg::SCORE_W + bnms_pkg::IDX_W + 2
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          advance,
    input  wire  [bnms_pkg::MODE_W-1:0]  mode,
    input  wire  [bnms_pkg::THR_W-1:0]   thr,
    input  wire  [REC_W-1:0]             sel_rec,
    input  wire  [REC_W-1:0]             in_rec,
    output logic [REC_W-1:0]             out_rec,
    output logic                         busy
);
    localparam int C       = COORD_BITS;
    localparam int DW      = C + 2;
    localparam int UW      = C + 1;
    localparam int PW      = 2 * UW;
    localparam int AW      = PW + 1;
    localparam int QW      = AW + bnms_pkg::THR_W;
    localparam int SUP_BIT = REC_W - 2;
    localparam int VAL_BIT = REC_W - 1;

    logic signed [C-1:0]  s_x0, s_y0, s_x1, s_y1, e_x0, e_y0, e_x1, e_y1;
    logic signed [C-1:0]  x1, y1, x2, y2;
    logic signed [DW-1:0] iw, ih, ew, eh, sw, sh;
    logic                 pos;
    logic                 hit;

    logic [REC_W-1:0] s1_rec_reg, s2_rec_reg, s3_rec_reg, s4_rec_reg;
    logic [UW-1:0]    s1_iw_reg, s1_ih_reg, s1_ew_reg, s1_eh_reg;
    logic             s1_pos_reg, s2_pos_reg, s3_pos_reg, s4_pos_reg;
    logic [PW-1:0]    s2_inter_reg, s2_ea_reg, s3_inter_reg, s4_inter_reg;
    logic [PW-1:0]    sarea_reg;
    logic [AW-1:0]    s3_den_reg, den_next;
    logic [QW-1:0]    s4_prod_reg;

    assign s_x0 = sel_rec[3*C +: C];
    assign s_y0 = sel_rec[2*C +: C];
    assign s_x1 = sel_rec[C +: C];
    assign s_y1 = sel_rec[0 +: C];
    assign e_x0 = in_rec[3*C +: C];
    assign e_y0 = in_rec[2*C +: C];
    assign e_x1 = in_rec[C +: C];
    assign e_y1 = in_rec[0 +: C];

    assign x1 = (s_x0 > e_x0) ? s_x0 : e_x0;
    assign y1 = (s_y0 > e_y0) ? s_y0 : e_y0;
    assign x2 = (s_x1 < e_x1) ? s_x1 : e_x1;
    assign y2 = (s_y1 < e_y1) ? s_y1 : e_y1;

    assign iw = DW'(x2) - DW'(x1) + DW'(bnms_pkg::PIX);
    assign ih = DW'(y2) - DW'(y1) + DW'(bnms_pkg::PIX);
    assign ew = DW'(e_x1) - DW'(e_x0) + DW'(bnms_pkg::PIX);
    assign eh = DW'(e_y1) - DW'(e_y0) + DW'(bnms_pkg::PIX);
    assign sw = DW'(s_x1) - DW'(s_x0) + DW'(bnms_pkg::PIX);
    assign sh = DW'(s_y1) - DW'(s_y0) + DW'(bnms_pkg::PIX);

    // positive overlap implies both areas are positive
    assign pos = !iw[DW-1] && (iw != '0) && !ih[DW-1] && (ih != '0);

    always_comb
    begin
        if (mode == bnms_pkg::MODE_IOU)
        begin
            den_next = AW'(s2_ea_reg) + AW'(sarea_reg) - AW'(s2_inter_reg);
        end
        else
        begin
            den_next = (s2_ea_reg < sarea_reg) ? AW'(s2_ea_reg) : AW'(sarea_reg);
        end
    end

    assign hit = s4_pos_reg &&
                 ((mode == bnms_pkg::MODE_IOU) || (mode == bnms_pkg::MODE_MIN)) &&
                 (QW'({s4_inter_reg, 16'b0}) > s4_prod_reg);

    always_comb
    begin
        out_rec          = s4_rec_reg;
        out_rec[SUP_BIT] = s4_rec_reg[SUP_BIT] | hit;
    end

    assign busy = s1_rec_reg[VAL_BIT] | s2_rec_reg[VAL_BIT] |
                  s3_rec_reg[VAL_BIT] | s4_rec_reg[VAL_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_rec_reg <= '0;
            s2_rec_reg <= '0;
            s3_rec_reg <= '0;
            s4_rec_reg <= '0;
        end
        else if (advance)
        begin
            s1_rec_reg <= in_rec;
            s2_rec_reg <= s1_rec_reg;
            s3_rec_reg <= s2_rec_reg;
            s4_rec_reg <= s3_rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sarea_reg <= sw[UW-1:0] * sh[UW-1:0];
        if (advance)
        begin
            s1_iw_reg    <= iw[UW-1:0];
            s1_ih_reg    <= ih[UW-1:0];
            s1_ew_reg    <= ew[UW-1:0];
            s1_eh_reg    <= eh[UW-1:0];
            s1_pos_reg   <= pos;
            s2_inter_reg <= s1_iw_reg * s1_ih_reg;
            s2_ea_reg    <= s1_ew_reg * s1_eh_reg;
            s2_pos_reg   <= s1_pos_reg;
            s3_inter_reg <= s2_inter_reg;
            s3_den_reg   <= den_next;
            s3_pos_reg   <= s2_pos_reg;
            s4_inter_reg <= s3_inter_reg;
            s4_prod_reg  <= thr * s3_den_reg;
            s4_pos_reg   <= s3_pos_reg;
        end
    end

endmodule
`default_nettype wire

>>> design/box_non_max_suppression.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Greedy score-ranked box suppression over a chain of box cells.
// ----------------------------------------------------------------------------
// Loading takes one box per cycle; each box up to MAX_BOXES is placed in rank order on
// arrival, and later boxes are dropped. After the last box, a suppressed head is shifted
// off and a kept head costs one full turn of the cell ring through the 4-stage overlap unit.
// Reset empties the chain, threshold 26214, mode intersection over union.
module box_non_max_suppression #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    bnms_box_if.sink    box_in,
    bnms_kept_if.source kept_out,
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    localparam int C       = COORD_BITS;
    localparam int REC_W   = 4 * C + bnms_pkg::SCORE_W + bnms_pkg::IDX_W + 2;
    localparam int SC_LSB  = 4 * C;
    localparam int IX_LSB  = SC_LSB + bnms_pkg::SCORE_W;
    localparam int SUP_BIT = REC_W - 2;
    localparam int VAL_BIT = REC_W - 1;
    localparam int CW      = $clog2(MAX_BOXES + 1);
    localparam int RW      = $clog2(MAX_BOXES + 5);

    bnms_pkg::state_t    st_reg, st_next;
    bnms_pkg::cell_ctl_t ctl;

    logic [bnms_pkg::THR_W-1:0]  thr_reg;
    logic [bnms_pkg::MODE_W-1:0] mode_reg;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        ovf_reg, ovf_next;
    logic [RW-1:0]               rot_reg, rot_next;
    logic [REC_W-1:0]            pend_reg, pend_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [REC_W-1:0]            sel_reg, sel_next;
    logic [REC_W-1:0]            out_rec_reg, out_rec_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_final_reg, out_final_next;
    logic                        out_drop_reg, out_drop_next;

    logic [REC_W-1:0] cell_rec   [MAX_BOXES];
    logic             cell_below [MAX_BOXES];
    logic [REC_W-1:0] new_rec;
    logic [REC_W-1:0] tail_rec;
    logic [REC_W-1:0] ovl_out;
    logic [REC_W-1:0] head;
    logic             ovl_busy;
    logic             in_fire;
    logic             out_free;

    assign head     = cell_rec[0];
    assign in_fire  = box_in.valid && box_in.ready;
    assign out_free = !out_valid_reg || kept_out.ready;
    assign box_in.ready = (st_reg == bnms_pkg::ST_LOAD);

    assign new_rec = {1'b1, 1'b0, bnms_pkg::IDX_W'(cnt_reg), box_in.box_score,
                      C'(box_in.box_x_min), C'(box_in.box_y_min),
                      C'(box_in.box_x_max), C'(box_in.box_y_max)};

    assign tail_rec = (st_reg == bnms_pkg::ST_ROT) ? ovl_out : '0;

    always_comb
    begin
        ctl.new_score = box_in.box_score;
        ctl.op        = bnms_pkg::OP_HOLD;
        case (st_reg)
            bnms_pkg::ST_LOAD:
            begin
                if (in_fire && (cnt_reg < CW'(MAX_BOXES)))
                begin
                    ctl.op = bnms_pkg::OP_INSERT;
                end
            end
            bnms_pkg::ST_SCAN:
            begin
                if (head[VAL_BIT] && (head[SUP_BIT] || !pend_valid_reg || out_free))
                begin
                    ctl.op = bnms_pkg::OP_SHIFT;
                end
            end
            bnms_pkg::ST_ROT:
            begin
                ctl.op = bnms_pkg::OP_SHIFT;
            end
            default:
            begin
                ctl.op = bnms_pkg::OP_HOLD;
            end
        endcase
    end

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        bnms_cell #(.COORD_BITS(C)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_rec    (new_rec),
            .left_rec   ((i == 0) ? {REC_W{1'b0}} : cell_rec[(i == 0) ? 0 : i - 1]),
            .right_rec  ((i == MAX_BOXES - 1) ? tail_rec
                                              : cell_rec[(i == MAX_BOXES - 1) ? i : i + 1]),
            .below_left ((i == 0) ? 1'b0 : cell_below[(i == 0) ? 0 : i - 1]),
            .rec        (cell_rec[i]),
            .below      (cell_below[i])
        );
    end

    bnms_overlap #(.COORD_BITS(C)) u_overlap (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (st_reg == bnms_pkg::ST_ROT),
        .mode    (mode_reg),
        .thr     (thr_reg),
        .sel_rec (sel_reg),
        .in_rec  (head),
        .out_rec (ovl_out),
        .busy    (ovl_busy)
    );

    always_comb
    begin
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        rot_next        = rot_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        sel_next        = sel_reg;
        out_rec_next    = out_rec_reg;
        out_final_next  = out_final_reg;
        out_drop_next   = out_drop_reg;
        out_valid_next  = out_valid_reg && !kept_out.ready;
        case (st_reg)
            bnms_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (cnt_reg < CW'(MAX_BOXES))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (box_in.last_box)
                    begin
                        st_next = bnms_pkg::ST_SCAN;
                    end
                end
            end
            bnms_pkg::ST_SCAN:
            begin
                if (head[VAL_BIT])
                begin
                    if (!head[SUP_BIT] && (!pend_valid_reg || out_free))
                    begin
                        // hand the previous keeper out, hold this one back
                        if (pend_valid_reg)
                        begin
                            out_rec_next   = pend_reg;
                            out_final_next = 1'b0;
                            out_drop_next  = ovf_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = head;
                        pend_valid_next = 1'b1;
                        sel_next        = head;
                        rot_next        = '0;
                        st_next         = bnms_pkg::ST_ROT;
                    end
                end
                else if (out_free)
                begin
                    out_rec_next    = pend_reg;
                    out_final_next  = 1'b1;
                    out_drop_next   = ovf_reg;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    ovf_next        = 1'b0;
                    st_next         = bnms_pkg::ST_LOAD;
                end
            end
            bnms_pkg::ST_ROT:
            begin
                rot_next = rot_reg + RW'(1);
                if (rot_reg == RW'(MAX_BOXES + 3))
                begin
                    st_next = bnms_pkg::ST_SCAN;
                end
            end
            default:
            begin
                st_next = bnms_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= bnms_pkg::ST_LOAD;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            rot_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= bnms_pkg::THR_RESET;
            mode_reg       <= bnms_pkg::MODE_RESET;
        end
        else
        begin
            st_reg         <= st_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            rot_reg        <= rot_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bnms_pkg::REG_THRESHOLD: thr_reg  <= cfg_data[bnms_pkg::THR_W-1:0];
                    bnms_pkg::REG_MODE:      mode_reg <= cfg_data[bnms_pkg::MODE_W-1:0];
                    default:                 thr_reg  <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        sel_reg       <= sel_next;
        out_rec_reg   <= out_rec_next;
        out_final_reg <= out_final_next;
        out_drop_reg  <= out_drop_next;
    end

    assign kept_out.valid        = out_valid_reg;
    assign kept_out.kept_x_min   = 16'(out_rec_reg[3*C +: C]);
    assign kept_out.kept_y_min   = 16'(out_rec_reg[2*C +: C]);
    assign kept_out.kept_x_max   = 16'(out_rec_reg[C +: C]);
    assign kept_out.kept_y_max   = 16'(out_rec_reg[0 +: C]);
    assign kept_out.kept_score   = out_rec_reg[SC_LSB +: bnms_pkg::SCORE_W];
    assign kept_out.kept_index   = out_rec_reg[IX_LSB +: bnms_pkg::IDX_W];
    assign kept_out.dropped_some = out_drop_reg;
    assign kept_out.final_kept   = out_final_reg;

    a_ring_empty_off_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != bnms_pkg::ST_ROT) |-> !ovl_busy)
        else $error("overlap pipeline holds boxes outside a ring turn");

    a_no_pending_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == bnms_pkg::ST_LOAD) |-> !pend_valid_reg)
        else $error("kept box left pending into next set");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_BOXES))
        else $error("load count beyond capacity");

    a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == bnms_pkg::ST_ROT) |-> (rot_reg <= RW'(MAX_BOXES + 3)))
        else $error("ring turn overran");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (kept_out.valid && !kept_out.ready) |=>
        (kept_out.valid && $stable(out_rec_reg) && $stable(out_final_reg)))
        else $error("waiting kept box changed");

endmodule
`default_nettype wire
